FILE: hw/rtl/mscd_pkg.sv
// Shared types and constants for the multiplexed scan change detector.
// Used by the front end, back end and top level; no dependencies.
`timescale 1ns / 1ps

package mscd_pkg;

  localparam int SMP_W  = 10;  // sample / control value width
  localparam int HYST_W = 10;  // hysteresis register width
  localparam int IDX_W  = 6;   // control index width
  localparam int CH_W   = 4;   // channel field width

  localparam int POT_COUNT  = 42;
  localparam int BTN_COUNT  = 33;
  localparam int BANK_OFS   = 16;
  localparam int BANK_C_OFS = 32;
  localparam int EXTRA_BTN  = 32;
  localparam int POT_AW     = $clog2(POT_COUNT);
  localparam int BTN_AW     = $clog2(BTN_COUNT);

  // Channels that carry a bank C pot, and the one with the extra button
  localparam int CH_POT_C0 = 0;
  localparam int CH_POT_C1 = 4;
  localparam int CH_POT_C2 = 9;
  localparam int CH_EXTRA  = 6;

  localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(3);

  localparam int ITEM_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH  = 4;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_PRIME = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_POT  = 2'd1,
    KIND_BTN  = 2'd2
  } kind_e;

  // Work slots of one item, in result order; the value is the mask bit
  typedef enum logic [2:0] {
    SL_POT_A = 3'd0,
    SL_POT_B = 3'd1,
    SL_POT_C = 3'd2,
    SL_BTN_A = 3'd3,
    SL_BTN_B = 3'd4,
    SL_BTN_X = 3'd5,
    SL_FIN   = 3'd6
  } slot_e;

  localparam int SLOT_W = 3;
  localparam int SLOT_N = 7;   // work slots plus the closing slot

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic                    prime;
    logic [SLOT_N-2:0]       mask;   // indexed by slot_e, closing slot excluded
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [IDX_W-1:0]        idx_c;
    logic [SMP_W-1:0]        smp_a;
    logic [SMP_W-1:0]        smp_b;
    logic [SMP_W-1:0]        smp_c;
    logic                    lvl_a;
    logic                    lvl_b;
    logic                    lvl_x;
    logic [CH_W-1:0]         channel;
  } mscd_item_t;

  // One result item
  typedef struct packed {
    kind_e                   kind;
    logic [IDX_W-1:0]        idx;
    logic [SMP_W-1:0]        value;
    logic [CH_W-1:0]         channel;
    logic                    last;
  } mscd_evt_t;

endpackage

FILE: hw/rtl/mscd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mscd_fifo.sv
// Small flop-based FIFO with occupancy count.
// No dependencies.
`timescale 1ns / 1ps

module mscd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

FILE: hw/rtl/mscd_front.sv
// Front end: accepts input items, advances the channel counter on scans and
// classifies each item into work slots. Depends on mscd_pkg.
`timescale 1ns / 1ps

module mscd_front
  import mscd_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [CH_W-1:0]  prime_channel_i,
  input  logic [SMP_W-1:0] pot_a_i,
  input  logic [SMP_W-1:0] pot_b_i,
  input  logic [SMP_W-1:0] pot_c_i,
  input  logic             button_a_level_i,
  input  logic             button_b_level_i,
  input  logic             extra_level_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output mscd_item_t       q_item_o
);

  localparam int CW    = $clog2(CHANNELS);
  localparam int SUM_W = ((CW > CH_W) ? CW : CH_W) + 2;

  logic [CW-1:0]    cnt_q, cnt_d, cnt_nxt;
  logic             accept;
  logic [SUM_W-1:0] ch, idx_a, idx_b, idx_c;
  logic             is_prime;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign is_prime   = (cmd_i == CMD_PRIME);

  assign cnt_nxt = (cnt_q == CW'(CHANNELS - 1)) ? '0 : cnt_q + 1'b1;
  assign cnt_d   = (accept && !is_prime) ? cnt_nxt : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign ch    = is_prime ? SUM_W'(prime_channel_i) : SUM_W'(cnt_nxt);
  assign idx_a = ch;
  assign idx_b = ch + SUM_W'(BANK_OFS);
  assign idx_c = ch + SUM_W'(BANK_C_OFS);

  always_comb begin
    q_item_o         = '0;
    q_item_o.prime   = is_prime;
    q_item_o.idx_a   = IDX_W'(idx_a);
    q_item_o.idx_b   = IDX_W'(idx_b);
    q_item_o.idx_c   = IDX_W'(idx_c);
    q_item_o.smp_a   = pot_a_i;
    q_item_o.smp_b   = pot_b_i;
    q_item_o.smp_c   = pot_c_i;
    q_item_o.lvl_a   = button_a_level_i;
    q_item_o.lvl_b   = button_b_level_i;
    q_item_o.lvl_x   = extra_level_i;
    q_item_o.channel = ch[CH_W-1:0];
    // drop any pot or button whose number falls outside its store
    q_item_o.mask[SL_POT_A] = idx_a < SUM_W'(POT_COUNT);
    q_item_o.mask[SL_POT_B] = idx_b < SUM_W'(POT_COUNT);
    if (is_prime) begin
      q_item_o.mask[SL_POT_C] = idx_c < SUM_W'(POT_COUNT);
    end else begin
      q_item_o.mask[SL_POT_C] = (ch == SUM_W'(CH_POT_C0)) || (ch == SUM_W'(CH_POT_C1))
                                || (ch == SUM_W'(CH_POT_C2));
      q_item_o.mask[SL_BTN_A] = idx_a < SUM_W'(BTN_COUNT);
      q_item_o.mask[SL_BTN_B] = idx_b < SUM_W'(BTN_COUNT);
      q_item_o.mask[SL_BTN_X] = (ch == SUM_W'(CH_EXTRA));
    end
  end

endmodule

FILE: hw/rtl/mscd_back.sv
// Back end: walks the work slots of each queued item, checks pots and
// buttons against their stores and orders the results. Depends on
// mscd_pkg, mscd_ram and mscd_fifo.
`timescale 1ns / 1ps

module mscd_back
  import mscd_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [HYST_W-1:0] hyst_i,
  input  logic              item_valid_i,
  input  mscd_item_t        item_i,
  output logic              item_pop_o,
  output logic              evt_valid_o,
  output mscd_evt_t         evt_o,
  input  logic              evt_ready_i
);

  localparam int SW    = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
  localparam int SUM_W = HYST_W + 1;
  localparam int OCW   = $clog2(OUT_Q_DEPTH + 1);

  // ---------------- slot sequencer ----------------
  logic              busy_q, busy_d;
  logic [SLOT_N-1:0] rem_q, rem_d, rem_cur, rem_nxt;
  slot_e             sel;
  logic              issue;
  logic [OCW-1:0]    o_count;
  logic              o_full, o_push;
  mscd_evt_t         o_data;

  logic              e_valid_q;
  slot_e             e_slot_q;
  logic              e_prime_q;
  logic [IDX_W-1:0]  e_idx_q;
  logic [SW-1:0]     e_smp_q;
  logic              e_lvl_q;
  logic [CH_W-1:0]   e_ch_q;

  logic [IDX_W-1:0]  r_idx;
  logic [SW-1:0]     r_smp;
  logic              r_lvl;

  assign rem_cur = busy_q ? rem_q : {1'b1, item_i.mask};

  always_comb begin
    sel = SL_FIN;
    for (int i = SLOT_N - 1; i >= 0; i--) begin
      if (rem_cur[i]) sel = slot_e'(SLOT_W'(i));
    end
  end

  assign rem_nxt = rem_cur & ~(SLOT_N'(1) << sel);

  // hold issue until the output queue has room for whatever E may push
  assign issue = item_valid_i &&
                 (({1'b0, o_count} + (OCW + 1)'(e_valid_q)) < (OCW + 1)'(OUT_Q_DEPTH));
  assign item_pop_o = issue && (sel == SL_FIN);

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    if (issue) begin
      busy_d = (sel != SL_FIN);
      rem_d  = rem_nxt;
    end
  end

  always_comb begin
    r_idx = '0;
    r_smp = '0;
    r_lvl = 1'b0;
    unique case (sel)
      SL_POT_A: begin r_idx = item_i.idx_a; r_smp = item_i.smp_a[SW-1:0]; end
      SL_POT_B: begin r_idx = item_i.idx_b; r_smp = item_i.smp_b[SW-1:0]; end
      SL_POT_C: begin r_idx = item_i.idx_c; r_smp = item_i.smp_c[SW-1:0]; end
      SL_BTN_A: begin r_idx = item_i.idx_a; r_lvl = item_i.lvl_a; end
      SL_BTN_B: begin r_idx = item_i.idx_b; r_lvl = item_i.lvl_b; end
      SL_BTN_X: begin r_idx = IDX_W'(EXTRA_BTN); r_lvl = item_i.lvl_x; end
      SL_FIN:   begin r_idx = '0; end
      default:  begin r_idx = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rem_q     <= '0;
      e_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      rem_q     <= rem_d;
      e_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      e_slot_q  <= sel;
      e_prime_q <= item_i.prime;
      e_idx_q   <= r_idx;
      e_smp_q   <= r_smp;
      e_lvl_q   <= r_lvl;
      e_ch_q    <= item_i.channel;
    end
  end

  // ---------------- stores ----------------
  logic [SW-1:0]        pot_rdata, pot_old;
  logic                 btn_rdata, btn_old, btn_new;
  logic [POT_COUNT-1:0] pot_vld_q;
  logic [BTN_COUNT-1:0] btn_vld_q;
  logic                 pot_we, btn_we;
  logic                 pwr_en_q, bwr_en_q;
  logic [POT_AW-1:0]    pwr_addr_q;
  logic [BTN_AW-1:0]    bwr_addr_q;
  logic [SW-1:0]        pwr_data_q;
  logic                 bwr_data_q;
  logic                 pot_fwd, btn_fwd;

  mscd_ram #(.WIDTH(SW), .DEPTH(POT_COUNT)) u_pot_ram (
    .clk_i   (clk_i),
    .we_i    (pot_we),
    .waddr_i (e_idx_q[POT_AW-1:0]),
    .wdata_i (e_smp_q),
    .re_i    (issue),
    .raddr_i (r_idx[POT_AW-1:0]),
    .rdata_o (pot_rdata)
  );

  mscd_ram #(.WIDTH(1), .DEPTH(BTN_COUNT)) u_btn_ram (
    .clk_i   (clk_i),
    .we_i    (btn_we),
    .waddr_i (e_idx_q[BTN_AW-1:0]),
    .wdata_i (btn_new),
    .re_i    (issue),
    .raddr_i (r_idx[BTN_AW-1:0]),
    .rdata_o (btn_rdata)
  );

  // ---------------- evaluate stage ----------------
  logic              is_pot, is_btn, is_fin;
  logic [SUM_W-1:0]  b_plus_h, s_plus_h;
  logic              moved, new_evt;
  mscd_evt_t         ev, pend_q;
  logic              pend_v_q;

  assign is_pot = e_valid_q && ((e_slot_q == SL_POT_A) || (e_slot_q == SL_POT_B) ||
                                (e_slot_q == SL_POT_C));
  assign is_btn = e_valid_q && ((e_slot_q == SL_BTN_A) || (e_slot_q == SL_BTN_B) ||
                                (e_slot_q == SL_BTN_X));
  assign is_fin = e_valid_q && (e_slot_q == SL_FIN);

  // a write in the previous cycle is not yet in the registered read data
  assign pot_fwd = pwr_en_q && (pwr_addr_q == e_idx_q[POT_AW-1:0]);
  assign btn_fwd = bwr_en_q && (bwr_addr_q == e_idx_q[BTN_AW-1:0]);

  assign pot_old = pot_fwd ? pwr_data_q :
                   (pot_vld_q[e_idx_q[POT_AW-1:0]] ? pot_rdata : '0);
  assign btn_old = btn_fwd ? bwr_data_q :
                   (btn_vld_q[e_idx_q[BTN_AW-1:0]] ? btn_rdata :
                    (e_idx_q == IDX_W'(EXTRA_BTN)));

  assign b_plus_h = SUM_W'(pot_old) + SUM_W'(hyst_i);
  assign s_plus_h = SUM_W'(e_smp_q) + SUM_W'(hyst_i);
  assign moved    = (SUM_W'(e_smp_q) > b_plus_h) || (s_plus_h < SUM_W'(pot_old));

  assign btn_new = (e_slot_q == SL_BTN_X) ? e_lvl_q : !e_lvl_q;

  assign pot_we  = is_pot && (e_prime_q || moved);
  assign btn_we  = is_btn && (btn_new != btn_old);
  assign new_evt = (is_pot && !e_prime_q && moved) || btn_we;

  always_comb begin
    ev         = '0;
    ev.kind    = is_pot ? KIND_POT : KIND_BTN;
    ev.idx     = e_idx_q;
    ev.value   = is_pot ? SMP_W'(e_smp_q) : SMP_W'(e_lvl_q);
    ev.channel = e_ch_q;
    ev.last    = 1'b0;
  end

  // keep the newest event back until it is known whether it is the last
  always_comb begin
    o_push = (new_evt && pend_v_q) || is_fin;
    o_data = pend_q;
    if (is_fin) begin
      if (!pend_v_q) begin
        o_data         = '0;
        o_data.kind    = KIND_NONE;
        o_data.channel = e_ch_q;
      end
      o_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q  <= 1'b0;
      pwr_en_q  <= 1'b0;
      bwr_en_q  <= 1'b0;
      pot_vld_q <= '0;
      btn_vld_q <= '0;
    end else begin
      if (new_evt) begin
        pend_v_q <= 1'b1;
      end else if (is_fin) begin
        pend_v_q <= 1'b0;
      end
      pwr_en_q <= pot_we;
      bwr_en_q <= btn_we;
      if (pot_we) pot_vld_q[e_idx_q[POT_AW-1:0]] <= 1'b1;
      if (btn_we) btn_vld_q[e_idx_q[BTN_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_evt) pend_q <= ev;
    pwr_addr_q <= e_idx_q[POT_AW-1:0];
    pwr_data_q <= e_smp_q;
    bwr_addr_q <= e_idx_q[BTN_AW-1:0];
    bwr_data_q <= btn_new;
  end

  mscd_fifo #(.WIDTH($bits(mscd_evt_t)), .DEPTH(OUT_Q_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  (o_data),
    .full_o  (o_full),
    .pop_i   (evt_valid_o && evt_ready_i),
    .valid_o (evt_valid_o),
    .data_o  (evt_o),
    .count_o (o_count)
  );

  // ---------------- checks ----------------
  a_out_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_push |-> !o_full)
    else $error("result pushed into a full output queue");

  a_pop_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (rem_nxt == '0))
    else $error("item released with work slots left");

  a_fin_flushes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_fin |=> !pend_v_q)
    else $error("pending event survived the end of its item");

endmodule

FILE: hw/rtl/mux_scan_change_detector.sv
// Top level of the multiplexed pot and button scan change detector.
// Depends on mscd_pkg, mscd_front, mscd_fifo and mscd_back.
`timescale 1ns / 1ps
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o): one item per scan step. cmd_i
//    selects a scan of the next channel or a prime of prime_channel_i.
//  - Output channel (out_valid_o / out_ready_i): one result item per event,
//    pots before buttons, or a single kind-none item; last_o marks the end.
//  - cfg_we_i / cfg_wdata_i write the hysteresis; write only while idle.
//  - The front end classifies an item into work slots and queues it; the back
//    end handles one slot per cycle while the output queue has room (bank A/B
//    pots, bank C pot, bank A/B buttons, extra button), then a closing slot.
//    Scans use the bank C slot on channels 0, 4 and 9 and the extra button
//    slot on channel 6; primes use pot slots only, bank C on channels 0 to 9.
//    That slot walk over the pot and button stores sets the rate.
//  - Idle back end: the first result enters the output queue when a second
//    event or the closing slot is evaluated, whichever comes first.
//  - Reset clears the channel counter, all pot baselines and button states
//    (extra button reads released) and loads a hysteresis of 3. Stores need
//    no clearing pass; per-entry valid bits stand in for the reset value.
//  - A stalled receiver fills the four-entry output queue, then the back end
//    holds, then the two-entry item queue fills and in_ready_o drops.

module mux_scan_change_detector
  import mscd_pkg::*;
#(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [CH_W-1:0]   prime_channel_i,
  input  logic [SMP_W-1:0]  pot_a_i,
  input  logic [SMP_W-1:0]  pot_b_i,
  input  logic [SMP_W-1:0]  pot_c_i,
  input  logic              button_a_level_i,
  input  logic              button_b_level_i,
  input  logic              extra_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [IDX_W-1:0]  control_index_o,
  output logic [SMP_W-1:0]  control_value_o,
  output logic [CH_W-1:0]   channel_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic [HYST_W-1:0] cfg_wdata_i
);

  logic [HYST_W-1:0] hyst_q;
  logic              q_push, q_full, q_pop, q_valid;
  mscd_item_t        q_in, q_out;
  mscd_evt_t         evt;

  // hysteresis register, written directly by the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= HYST_RESET;
    end else if (cfg_we_i) begin
      hyst_q <= cfg_wdata_i;
    end
  end

  // front end: accept, advance the channel counter, classify
  mscd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .prime_channel_i  (prime_channel_i),
    .pot_a_i          (pot_a_i),
    .pot_b_i          (pot_b_i),
    .pot_c_i          (pot_c_i),
    .button_a_level_i (button_a_level_i),
    .button_b_level_i (button_b_level_i),
    .extra_level_i    (extra_level_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_item_o         (q_in)
  );

  // short queue that decouples classification from execution
  mscd_fifo #(.WIDTH($bits(mscd_item_t)), .DEPTH(ITEM_Q_DEPTH)) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out),
    .count_o ()
  );

  // back end: pot and button checks, result ordering, output queue
  mscd_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hyst_i       (hyst_q),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .evt_valid_o  (out_valid_o),
    .evt_o        (evt),
    .evt_ready_i  (out_ready_i)
  );

  assign kind_o          = evt.kind;
  assign control_index_o = evt.idx;
  assign control_value_o = evt.value;
  assign channel_o       = evt.channel;
  assign last_o          = evt.last;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for mux_scan_change_detector: directed edge cases, then
// random scan and prime items under several hysteresis settings and random stalls.
// Depends on mscd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import mscd_pkg::*;

  localparam int CHANNELS     = 16;
  localparam int MAX_GAP      = 4;
  localparam int HOLD_CYCLES  = 120;  // long receiver stall, enough to back up the input
  localparam int TAIL_CYCLES  = 30;   // settle time after the last expected event
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 52;
  localparam int SMP_MAX      = (1 << SMP_W) - 1;

  // Predicts the event items of the scanner and holds them until they come out.
  class panel_event_board;
    logic [CH_W-1:0]   chan_count;
    int unsigned       baseline [POT_COUNT];
    bit                pressed [BTN_COUNT];  // extra button entry holds its raw level
    int unsigned       hyst;
    mscd_evt_t         step_q[$];
    mscd_evt_t         event_q[$];
    int                errors;
    int                n_items, n_prime, n_pot, n_btn, n_quiet;

    function new();
      chan_count = '0;
      foreach (baseline[i]) baseline[i] = 0;
      foreach (pressed[i]) pressed[i] = 1'b0;
      pressed[EXTRA_BTN] = 1'b1;
      hyst = HYST_RESET;
      errors = 0;
      n_items = 0;
      n_prime = 0;
      n_pot = 0;
      n_btn = 0;
      n_quiet = 0;
    endfunction

    function void push_evt(kind_e k, int unsigned idx, int unsigned v, logic [CH_W-1:0] ch);
      mscd_evt_t ev;
      ev.kind    = k;
      ev.idx     = IDX_W'(idx);
      ev.value   = SMP_W'(v);
      ev.channel = ch;
      ev.last    = 1'b0;
      step_q.push_back(ev);
    endfunction

    // A pot reports only when it leaves the dead band; the baseline follows it.
    function void probe_pot(int unsigned idx, int unsigned s, logic [CH_W-1:0] ch);
      if (idx >= POT_COUNT) return;
      if (s > baseline[idx] + hyst || s + hyst < baseline[idx]) begin
        baseline[idx] = s;
        push_evt(KIND_POT, idx, s, ch);
        n_pot++;
      end
    endfunction

    function void probe_button(int unsigned idx, bit now, logic level, logic [CH_W-1:0] ch);
      if (idx >= BTN_COUNT) return;
      if (now != pressed[idx]) begin
        pressed[idx] = now;
        push_evt(KIND_BTN, idx, level, ch);
        n_btn++;
      end
    endfunction

    function void note_scan_item(logic cmd, logic [CH_W-1:0] prime_ch,
                                 logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                 logic [SMP_W-1:0] c, logic la, logic lb, logic le);
      logic [CH_W-1:0] ch;
      step_q.delete();
      n_items++;
      if (cmd == CMD_PRIME) begin
        ch = prime_ch;
        baseline[ch] = a;
        baseline[ch + BANK_OFS] = b;
        if (ch + BANK_C_OFS < POT_COUNT) baseline[ch + BANK_C_OFS] = c;
        n_prime++;
      end else begin
        ch = (chan_count == CHANNELS - 1) ? '0 : chan_count + 1'b1;
        chan_count = ch;
        probe_pot(ch, a, ch);
        probe_pot(ch + BANK_OFS, b, ch);
        if (ch == CH_POT_C0 || ch == CH_POT_C1 || ch == CH_POT_C2)
          probe_pot(ch + BANK_C_OFS, c, ch);
        probe_button(ch, la == 1'b0, la, ch);
        probe_button(ch + BANK_OFS, lb == 1'b0, lb, ch);
        if (ch == CH_EXTRA) probe_button(EXTRA_BTN, le, le, ch);
      end
      if (step_q.size() == 0) begin
        push_evt(KIND_NONE, 0, 0, ch);
        n_quiet++;
      end
      step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) event_q.push_back(step_q[i]);
    endfunction

    function string evt_str(mscd_evt_t e);
      return $sformatf("kind %0d index %0d value %0d channel %0d last %0b",
                       e.kind, e.idx, e.value, e.channel, e.last);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t ns MISMATCH %s", $time, msg);
    endfunction

    function void check_event(mscd_evt_t got);
      mscd_evt_t want;
      if (event_q.size() == 0) begin
        flag({"unexpected event: ", evt_str(got)});
        return;
      end
      want = event_q.pop_front();
      if (got.kind !== want.kind || got.idx !== want.idx || got.value !== want.value ||
          got.channel !== want.channel || got.last !== want.last)
        flag({"want ", evt_str(want), " / got ", evt_str(got)});
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              cmd_i;
  logic [CH_W-1:0]   prime_channel_i;
  logic [SMP_W-1:0]  pot_a_i;
  logic [SMP_W-1:0]  pot_b_i;
  logic [SMP_W-1:0]  pot_c_i;
  logic              button_a_level_i;
  logic              button_b_level_i;
  logic              extra_level_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        kind_o;
  logic [IDX_W-1:0]  control_index_o;
  logic [SMP_W-1:0]  control_value_o;
  logic [CH_W-1:0]   channel_o;
  logic              last_o;
  logic              cfg_we_i;
  logic [HYST_W-1:0] cfg_wdata_i;

  panel_event_board sb = new();

  bit no_idle;      // when set, neither side inserts gaps
  bit rx_hold;      // long receiver stall in progress
  bit pressure_go;  // kicks off the long stall
  int rx_gap;       // cycles the receiver still idles
  int n_settings;

  mux_scan_change_detector #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SMP_W)
  ) DUT (.*);

  // Clock: 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Pick a sample for pot number idx: extremes, anything, or right at the
  // edges of the dead band around the current baseline.
  function automatic logic [SMP_W-1:0] pick_sample(int idx);
    int b;
    int h;
    int v;
    b = (idx < POT_COUNT) ? int'(sb.baseline[idx]) : 0;
    h = sb.hyst;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = SMP_MAX;
      2, 3: v = $urandom_range(0, SMP_MAX);
      default: v = $urandom_range(0, 1) ? b + h + $urandom_range(0, 2) - 1
                                        : b - h - $urandom_range(0, 2) + 1;
    endcase
    if (v < 0) v = 0;
    if (v > SMP_MAX) v = SMP_MAX;
    return SMP_W'(v);
  endfunction

  // Offer one item after a random gap; hold it until accepted, then log it.
  task automatic send_item(logic cmd, logic [CH_W-1:0] pch, logic [SMP_W-1:0] a,
                           logic [SMP_W-1:0] b, logic [SMP_W-1:0] c,
                           logic la, logic lb, logic le);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    prime_channel_i  <= pch;
    pot_a_i          <= a;
    pot_b_i          <= b;
    pot_c_i          <= c;
    button_a_level_i <= la;
    button_b_level_i <= lb;
    extra_level_i    <= le;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_scan_item(cmd, pch, a, b, c, la, lb, le);
  endtask

  // Mostly scans; levels flip against the stored state about a third of the time.
  task automatic random_item();
    logic            cmd;
    logic [CH_W-1:0] pch;
    logic [CH_W-1:0] ch;
    logic            la;
    logic            lb;
    logic            le;
    cmd = ($urandom_range(0, 4) == 0) ? CMD_PRIME : CMD_SCAN;
    pch = CH_W'($urandom_range(0, CHANNELS - 1));
    if (cmd == CMD_PRIME) ch = pch;
    else ch = (sb.chan_count == CHANNELS - 1) ? '0 : sb.chan_count + 1'b1;
    la = ($urandom_range(0, 2) == 0) ? sb.pressed[ch] : !sb.pressed[ch];
    lb = ($urandom_range(0, 2) == 0) ? sb.pressed[ch + BANK_OFS] : !sb.pressed[ch + BANK_OFS];
    le = ($urandom_range(0, 2) == 0) ? !sb.pressed[EXTRA_BTN] : sb.pressed[EXTRA_BTN];
    send_item(cmd, pch, pick_sample(ch), pick_sample(ch + BANK_OFS),
              pick_sample(ch + BANK_C_OFS), la, lb, le);
  endtask

  // Drop valid and wait until every predicted event has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.event_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the dead band while the block is idle.
  task automatic write_hysteresis(logic [HYST_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.hyst = v;
    n_settings++;
  endtask

  // Receiver: sample at the rising edge, check, and draw the next gap.
  initial begin
    mscd_evt_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.kind    = kind_e'(kind_o);
        got.idx     = control_index_o;
        got.value   = control_value_o;
        got.channel = channel_o;
        got.last    = last_o;
        sb.check_event(got);
        rx_gap = draw_gap();
      end
    end
  end

  // Receiver: drive ready at the falling edge; hold it low during a stall.
  initial begin
    out_ready_i = 1'b0;
    rx_gap = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        rx_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Long stall: the output queue fills, the back end holds, in_ready drops.
  initial begin
    rx_hold = 1'b0;
    wait (pressure_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    logic [HYST_W-1:0] settings [5];
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = CMD_SCAN;
    prime_channel_i  = '0;
    pot_a_i          = '0;
    pot_b_i          = '0;
    pot_c_i          = '0;
    button_a_level_i = 1'b1;
    button_b_level_i = 1'b1;
    extra_level_i    = 1'b1;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    no_idle          = 1'b0;
    pressure_go      = 1'b0;
    n_settings       = 1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset dead band of 3. Prime a few channels
    // first: bank C ones, the last channel, and one with no bank C pot.
    send_item(CMD_PRIME, 4'd0, 10'd512, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b1);
    send_item(CMD_PRIME, 4'd4, 10'd1023, 10'd500, 10'd1023, 1'b0, 1'b1, 1'b0);
    send_item(CMD_PRIME, 4'd9, 10'd0, 10'd1023, 10'd0, 1'b1, 1'b1, 1'b1);
    send_item(CMD_PRIME, 4'd15, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0);
    send_item(CMD_PRIME, 4'd10, 10'd7, 10'd8, 10'd777, 1'b1, 1'b0, 1'b1);
    // Walk every channel once and wrap past 15; samples sit on and just past
    // the dead band, and the extra button drops on its channel.
    for (int j = 1; j <= CHANNELS + 1; j++) begin
      send_item(CMD_SCAN, CH_W'(j),
                (j % 3 == 0) ? 10'd1023 : (j % 3 == 1) ? 10'd4 : 10'd3,
                (j % 2 == 1) ? 10'd0 : 10'd1023,
                (j % 2 == 1) ? 10'd4 : 10'd1023,
                j[0], j[1], (j % CHANNELS == CH_EXTRA) ? 1'b0 : 1'b1);
    end
    drain();

    // Random phases: closed and widest dead band, two random ones, then reset value.
    settings[0] = '0;
    settings[1] = '1;
    settings[2] = HYST_W'($urandom_range(1, SMP_MAX - 1));
    settings[3] = HYST_W'($urandom_range(1, 40));
    settings[4] = HYST_RESET;
    for (int p = 0; p < 5; p++) begin
      write_hysteresis(settings[p]);
      no_idle = (p == 2);
      if (p == 2) pressure_go = 1'b1;
      repeat (PHASE_ITEMS) random_item();
      drain();
    end
    no_idle = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.event_q.size() != 0) begin
      $display("%0d predicted events never came out", sb.event_q.size());
      sb.errors += sb.event_q.size();
    end

    $display("Ran %0d items (%0d primes) over %0d dead band settings, incl. a long stall.",
             sb.n_items, sb.n_prime, n_settings);
    $display("Checked %0d pot moves, %0d button changes, %0d quiet items; %0d mismatches.",
             sb.n_pot, sb.n_btn, sb.n_quiet, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
